### rtl/hrx_pkg.sv
// Shared types and constants for the Huffman/RLE/row-XOR image decoder.
`default_nettype none

package hrx_pkg;

  localparam int unsigned MaxWidth   = 512;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned TreeSize   = 256;
  localparam int unsigned PixPerWord = 16;

  localparam int unsigned TreeAddrW = $clog2(TreeSize);
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned WidthW    = 10;
  localparam int unsigned HeightW   = 11;
  localparam int unsigned RepsW     = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [7:0] RunBase  = 8'h90;
  localparam logic [7:0] LeafMark = 8'h80;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2,
    OP_NONE  = 2'd3
  } hrx_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RSVD2  = 2'd2,
    REG_RSVD3  = 2'd3
  } hrx_reg_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] tree_address;
    logic [7:0] data_byte;
  } hrx_in_t;

  typedef struct packed {
    logic [63:0] pixel_word;
    logic [4:0]  pixel_count;
    logic        image_done;
    logic        last_of_item;
  } hrx_out_t;

  typedef struct packed {
    logic push;
    logic flush;
  } hrx_ob_ctrl_t;

  typedef struct packed {
    logic pend_valid;
    logic out_free;
  } hrx_ob_stat_t;

endpackage

`default_nettype wire

### rtl/hrx_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
`default_nettype none

module hrx_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/hrx_out_buf.sv
// Result holding stage: one pending word plus the output register.
`default_nettype none

module hrx_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hrx_pkg::hrx_ob_ctrl_t ctrl_i,
  input  wire hrx_pkg::hrx_out_t res_i,
  output hrx_pkg::hrx_ob_stat_t  stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hrx_pkg::hrx_out_t      out_data_o
);

  logic              pend_valid_q, pend_valid_d;
  hrx_pkg::hrx_out_t pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  hrx_pkg::hrx_out_t out_q, out_d;
  logic              out_free;

  // pending word is held back until we know whether it ends the item
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    if (ctrl_i.push) begin
      if (pend_valid_q) begin
        out_valid_d        = 1'b1;
        out_d              = pend_q;
        out_d.last_of_item = 1'b0;
      end
      pend_valid_d        = 1'b1;
      pend_d              = res_i;
      pend_d.last_of_item = 1'b0;
    end else if (ctrl_i.flush && pend_valid_q) begin
      out_valid_d        = 1'b1;
      out_d              = pend_q;
      out_d.last_of_item = 1'b1;
      pend_valid_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

### rtl/huffman_rle_xor_row_decoder_top.sv
// Top level: tree walker, run expander and row-XOR line store control.
// A data byte is accepted in S_IDLE, then walks S_TREE_RD and S_TREE_EV per
//   tree bit and S_PIX_RD and S_PIX_WR per pixel before S_DONE, stretched by
//   output back-pressure. A tree load is written on accept; an image start runs
//   a 512-entry line store clearing pass (tree and line RAM reads are sync).
// After reset (rst_ni async, active low) the same clearing pass runs first.
`default_nettype none

module huffman_rle_xor_row_decoder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire hrx_pkg::hrx_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hrx_pkg::hrx_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hrx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [hrx_pkg::CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_TREE_RD = 7'b0000100,
    S_TREE_EV = 7'b0001000,
    S_PIX_RD  = 7'b0010000,
    S_PIX_WR  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [hrx_pkg::WidthW-1:0]  cfg_width_q;
  logic [hrx_pkg::HeightW-1:0] cfg_height_q;
  logic [hrx_pkg::WidthW-1:0]  eff_w;
  logic [hrx_pkg::HeightW-1:0] eff_h;

  logic [7:0]                  byte_q, byte_d;
  logic [2:0]                  bit_idx_q, bit_idx_d;
  logic [6:0]                  node_q, node_d;
  logic [3:0]                  colour_q, colour_d;
  logic [hrx_pkg::ColW-1:0]    col_q, col_d;
  logic [hrx_pkg::HeightW-1:0] row_q, row_d;
  logic [63:0]                 pack_word_q, pack_word_d;
  logic [4:0]                  pack_fill_q, pack_fill_d;
  logic                        finished_q, finished_d;
  logic [hrx_pkg::RepsW-1:0]   reps_q, reps_d;
  logic [hrx_pkg::ColW-1:0]    clr_addr_q, clr_addr_d;

  logic                              in_acc;
  hrx_pkg::hrx_op_e                  in_op;
  logic                              tree_we;
  logic [hrx_pkg::TreeAddrW-1:0]     tree_raddr;
  logic [7:0]                        tree_rdata_w;
  logic [7:0]                        leaf;
  logic                              line_we;
  logic [hrx_pkg::ColW-1:0]          line_waddr;
  logic [3:0]                        line_wdata;
  logic [3:0]                        line_rdata;

  logic [3:0]                  pix_v;
  logic [4:0]                  fill_inc;
  logic [hrx_pkg::WidthW-1:0]  col_inc;
  logic [hrx_pkg::HeightW-1:0] row_inc;
  logic                        row_end;
  logic                        fin_new;
  logic                        emit;
  logic [63:0]                 word_new;
  logic [7:0]                  run_len;
  logic                        pix_go;

  hrx_pkg::hrx_ob_ctrl_t ob_ctrl;
  hrx_pkg::hrx_ob_stat_t ob_stat;
  hrx_pkg::hrx_out_t     res;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= hrx_pkg::WidthW'(480);
      cfg_height_q <= hrx_pkg::HeightW'(300);
    end else if (cfg_valid_i) begin
      unique case (hrx_pkg::hrx_reg_e'(cfg_index_i))
        hrx_pkg::REG_WIDTH:  cfg_width_q  <= cfg_data_i[hrx_pkg::WidthW-1:0];
        hrx_pkg::REG_HEIGHT: cfg_height_q <= cfg_data_i[hrx_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = hrx_pkg::WidthW'(1);
    end else if (cfg_width_q > hrx_pkg::WidthW'(hrx_pkg::MaxWidth)) begin
      eff_w = hrx_pkg::WidthW'(hrx_pkg::MaxWidth);
    end else begin
      eff_w = cfg_width_q;
    end
    if (cfg_height_q == '0) begin
      eff_h = hrx_pkg::HeightW'(1);
    end else if (cfg_height_q > hrx_pkg::HeightW'(hrx_pkg::MaxHeight)) begin
      eff_h = hrx_pkg::HeightW'(hrx_pkg::MaxHeight);
    end else begin
      eff_h = cfg_height_q;
    end
  end

  // ---------------- memories ----------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_op      = hrx_pkg::hrx_op_e'(in_data_i.opcode);
  assign tree_we    = in_acc && (in_op == hrx_pkg::OP_LOAD);
  assign tree_raddr = {node_q, byte_q[bit_idx_q]};
  assign leaf       = tree_rdata_w;

  hrx_ram #(
    .Depth (hrx_pkg::TreeSize),
    .Width (8)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (in_data_i.tree_address),
    .wdata_i (in_data_i.data_byte),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata_w)
  );

  hrx_ram #(
    .Depth (hrx_pkg::MaxWidth),
    .Width (4)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // ---------------- pixel datapath ----------------
  assign pix_v    = line_rdata ^ colour_q;
  assign fill_inc = pack_fill_q + 5'd1;
  assign col_inc  = {1'b0, col_q} + hrx_pkg::WidthW'(1);
  assign row_inc  = row_q + hrx_pkg::HeightW'(1);
  assign row_end  = (col_inc >= eff_w);
  assign fin_new  = row_end && (row_inc >= eff_h);
  assign emit     = fin_new || (fill_inc == 5'(hrx_pkg::PixPerWord));
  assign word_new = pack_word_q | (64'(pix_v) << {pack_fill_q[3:0], 2'b00});
  assign run_len  = leaf - (hrx_pkg::RunBase - 8'd1);
  // stall a pixel only when its word would displace an unsent pending word
  assign pix_go   = (state_q == S_PIX_WR) &&
                    !(emit && ob_stat.pend_valid && !ob_stat.out_free);

  assign line_we    = (state_q == S_CLEAR) || pix_go;
  assign line_waddr = (state_q == S_CLEAR) ? clr_addr_q : col_q;
  assign line_wdata = (state_q == S_CLEAR) ? 4'd0 : pix_v;

  assign res.pixel_word   = word_new;
  assign res.pixel_count  = fill_inc;
  assign res.image_done   = fin_new;
  assign res.last_of_item = 1'b0;

  // ---------------- control ----------------
  always_comb begin
    state_d       = state_q;
    byte_d        = byte_q;
    bit_idx_d     = bit_idx_q;
    node_d        = node_q;
    colour_d      = colour_q;
    col_d         = col_q;
    row_d         = row_q;
    pack_word_d   = pack_word_q;
    pack_fill_d   = pack_fill_q;
    finished_d    = finished_q;
    reps_d        = reps_q;
    clr_addr_d    = clr_addr_q;
    ob_ctrl.push  = 1'b0;
    ob_ctrl.flush = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + hrx_pkg::ColW'(1);
        if (clr_addr_q == hrx_pkg::ColW'(hrx_pkg::MaxWidth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == hrx_pkg::OP_START) begin
            node_d      = '0;
            colour_d    = '0;
            col_d       = '0;
            row_d       = '0;
            pack_word_d = '0;
            pack_fill_d = '0;
            finished_d  = 1'b0;
            clr_addr_d  = '0;
            state_d     = S_CLEAR;
          end else if (in_op == hrx_pkg::OP_DATA && !finished_q) begin
            byte_d    = in_data_i.data_byte;
            bit_idx_d = 3'd7;
            state_d   = S_TREE_RD;
          end
        end
      end
      S_TREE_RD: begin
        state_d = S_TREE_EV;
      end
      S_TREE_EV: begin
        if (leaf < hrx_pkg::LeafMark) begin
          node_d = leaf[6:0];
          if (bit_idx_q == 3'd0) begin
            state_d = S_DONE;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            state_d   = S_TREE_RD;
          end
        end else begin
          node_d = '0;
          if (leaf >= hrx_pkg::RunBase) begin
            reps_d = run_len[hrx_pkg::RepsW-1:0];
          end else begin
            colour_d = leaf[3:0];
            reps_d   = hrx_pkg::RepsW'(1);
          end
          state_d = S_PIX_RD;
        end
      end
      S_PIX_RD: begin
        state_d = S_PIX_WR;
      end
      S_PIX_WR: begin
        if (pix_go) begin
          if (row_end) begin
            col_d = '0;
            row_d = row_inc;
          end else begin
            col_d = col_inc[hrx_pkg::ColW-1:0];
          end
          finished_d = fin_new;
          if (emit) begin
            ob_ctrl.push = 1'b1;
            pack_word_d  = '0;
            pack_fill_d  = '0;
          end else begin
            pack_word_d = word_new;
            pack_fill_d = fill_inc;
          end
          reps_d = reps_q - hrx_pkg::RepsW'(1);
          if (fin_new) begin
            state_d = S_DONE;
          end else if (reps_q != hrx_pkg::RepsW'(1)) begin
            state_d = S_PIX_RD;
          end else if (bit_idx_q == 3'd0) begin
            state_d = S_DONE;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            state_d   = S_TREE_RD;
          end
        end
      end
      S_DONE: begin
        if (!ob_stat.pend_valid || ob_stat.out_free) begin
          ob_ctrl.flush = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      node_q      <= '0;
      colour_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pack_word_q <= '0;
      pack_fill_q <= '0;
      finished_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      node_q      <= node_d;
      colour_q    <= colour_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pack_word_q <= pack_word_d;
      pack_fill_q <= pack_fill_d;
      finished_q  <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    bit_idx_q <= bit_idx_d;
    reps_q    <= reps_d;
  end

  hrx_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ob_ctrl),
    .res_i       (res),
    .stat_o      (ob_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // ---------------- assertions ----------------
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ob_stat.pend_valid)
    else $error("pending result left over at item boundary");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_count != 5'd0) &&
                    (out_data_o.pixel_count <= 5'(hrx_pkg::PixPerWord)))
    else $error("pixel_count out of range");

  a_finish_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(finished_q) |-> (state_q == S_DONE))
    else $error("decoding continued past image end");

  a_no_line_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !line_we)
    else $error("line store written while idle");

endmodule

`default_nettype wire

### verif/huffman_rle_xor_row_decoder_top_tb.sv
// Self-checking testbench for the Huffman/RLE/row-XOR image decoder top level.
`timescale 1ns / 100ps

module huffman_rle_xor_row_decoder_top_tb;
  import hrx_pkg::*;

  localparam int unsigned SettleCycles = 600;
  localparam int unsigned LongStall    = 400;
  // random trees only point at nodes below 32, so only these entries are read
  localparam int unsigned TreeLoaded   = 64;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  hrx_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  hrx_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  huffman_rle_xor_row_decoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Decoder state as seen by the predictor
  logic [7:0]   tree_mem [TreeSize];
  logic [3:0]   line_mem [MaxWidth];
  logic [6:0]   walk_node;
  logic [3:0]   cur_colour;
  int unsigned  col_pos;
  int unsigned  row_pos;
  logic [63:0]  pack_acc;
  int unsigned  pack_fill;
  logic         img_done;
  logic [9:0]   cfg_width;
  logic [10:0]  cfg_height;
  hrx_out_t     held_word;
  logic         held_valid;
  hrx_out_t     expected_words[$];

  int unsigned  send_gap_pct   = 0;
  int unsigned  recv_stall_pct = 0;
  logic         stall_req      = 1'b0;
  int unsigned  stall_left     = 0;
  int unsigned  err_cnt        = 0;
  int unsigned  beats_sent     = 0;
  int unsigned  words_seen     = 0;
  int unsigned  images_seen    = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MaxWidth) return MaxWidth;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MaxHeight) return MaxHeight;
    return cfg_height;
  endfunction

  function automatic void clear_image();
    foreach (line_mem[i]) line_mem[i] = '0;
    walk_node  = '0;
    cur_colour = '0;
    col_pos    = 0;
    row_pos    = 0;
    pack_acc   = '0;
    pack_fill  = 0;
    img_done   = 1'b0;
    held_valid = 1'b0;
  endfunction

  function automatic void pack_pixel();
    logic [3:0]  pix;
    int unsigned c;
    c = (col_pos >= MaxWidth) ? 0 : col_pos;
    pix = line_mem[c] ^ cur_colour;
    line_mem[c] = pix;
    pack_acc |= 64'(pix) << (4 * pack_fill);
    pack_fill++;
    c++;
    if (c >= eff_width()) begin
      c = 0;
      row_pos++;
      if (row_pos >= eff_height()) img_done = 1'b1;
    end
    col_pos = c;
    if (img_done || pack_fill >= PixPerWord) begin
      // hold one word back so the last one of the beat can be tagged
      if (held_valid) expected_words.push_back(held_word);
      held_word.pixel_word   = pack_acc;
      held_word.pixel_count  = 5'(pack_fill);
      held_word.image_done   = img_done;
      held_word.last_of_item = 1'b0;
      held_valid = 1'b1;
      pack_acc   = '0;
      pack_fill  = 0;
    end
  endfunction

  function automatic void decode_item(hrx_in_t it);
    logic [7:0]  entry;
    int unsigned reps;
    case (it.opcode)
      OP_LOAD:  tree_mem[it.tree_address] = it.data_byte;
      OP_START: clear_image();
      OP_DATA: begin
        for (int b = 7; b >= 0 && !img_done; b--) begin
          entry = tree_mem[{walk_node, it.data_byte[b]}];
          if (entry < LeafMark) begin
            walk_node = entry[6:0];
          end else begin
            walk_node = '0;
            if (entry >= RunBase) begin
              reps = entry - RunBase + 1;
            end else begin
              cur_colour = entry[3:0];
              reps = 1;
            end
            for (int k = 0; k < reps && !img_done; k++) pack_pixel();
          end
        end
        if (held_valid) begin
          held_word.last_of_item = 1'b1;
          expected_words.push_back(held_word);
          held_valid = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_word(hrx_out_t got);
    hrx_out_t want;
    words_seen++;
    if (got.image_done) images_seen++;
    if (expected_words.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected output beat, expected none, actual %h", $time, got);
      return;
    end
    want = expected_words.pop_front();
    check_field("pixel_word", want.pixel_word, got.pixel_word);
    check_field("pixel_count", 64'(want.pixel_count), 64'(got.pixel_count));
    check_field("image_done", 64'(want.image_done), 64'(got.image_done));
    check_field("last_of_item", 64'(want.last_of_item), 64'(got.last_of_item));
  endfunction

  // Output side: random or long hold-off, and checking of every accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_word(out_data_o);
      if (stall_req) begin
        stall_left = LongStall;
        stall_req  = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(hrx_op_e op, logic [7:0] addr, logic [7:0] data);
    hrx_in_t it;
    it.opcode       = op;
    it.tree_address = addr;
    it.data_byte    = data;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    decode_item(it);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    // a beat with no output may still be walking, or the line store clearing
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(hrx_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WIDTH:  cfg_width  = val[9:0];
      REG_HEIGHT: cfg_height = val[10:0];
      default: ;
    endcase
  endtask

  task automatic resize(int unsigned w, int unsigned h, logic poke_spare);
    logic [5:0] w_junk;
    logic [4:0] h_junk;
    w_junk = ($urandom_range(3) == 0) ? 6'($urandom) : '0;
    h_junk = ($urandom_range(3) == 0) ? 5'($urandom) : '0;
    wait_quiet();
    write_reg(REG_WIDTH, {w_junk, 10'(w)});
    write_reg(REG_HEIGHT, {h_junk, 11'(h)});
    if (poke_spare) write_reg(REG_RSVD2, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_entry();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 35) return 8'($urandom_range(31));
    if (p < 70) return LeafMark + 8'($urandom_range(15));
    if (p < 92) return RunBase + 8'($urandom_range(15));
    return RunBase + 8'($urandom_range(111));
  endfunction

  // Fill the reachable entries; the first three nodes get a known shape
  task automatic test_tree_load();
    logic [7:0] entry;
    for (int a = 0; a < TreeLoaded; a++) begin
      case (a)
        0:       entry = 8'h01;
        1:       entry = LeafMark + 8'd5;
        2:       entry = RunBase + 8'd3;
        3:       entry = 8'h02;
        4:       entry = RunBase + 8'd111;
        5:       entry = 8'h02;
        default: entry = rand_entry();
      endcase
      send_item(OP_LOAD, 8'(a), entry);
    end
  endtask

  task automatic test_directed();
    resize(5, 3, 1'b0);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    send_item(OP_NONE, 8'($urandom), 8'($urandom));
    // park the walk on the self-looping node, then rewrite a leaf under it
    send_item(OP_DATA, 8'($urandom), 8'h7F);
    send_item(OP_LOAD, 8'd4, LeafMark + 8'd12);
    send_item(OP_DATA, 8'($urandom), 8'h3F);
    send_item(OP_DATA, 8'($urandom), 8'h00);
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    // second row XORs against the first
    send_item(OP_START, 8'($urandom), 8'($urandom));
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    send_item(OP_LOAD, 8'd0, 8'h00);
    send_item(OP_DATA, 8'($urandom), 8'h00);
    send_item(OP_DATA, 8'($urandom), 8'h80);
    send_item(OP_LOAD, 8'd0, 8'h01);
    send_item(OP_LOAD, 8'd255, 8'hFF);
    send_item(OP_LOAD, 8'd4, RunBase + 8'd111);
    send_item(OP_DATA, 8'($urandom), 8'h7F);
    send_item(OP_DATA, 8'($urandom), 8'h00);
  endtask

  task automatic test_size_extremes();
    resize(0, 0, 1'b1);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    resize(1023, 2047, 1'b0);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    // every bit a maximal run: the most words one beat can give
    send_item(OP_LOAD, 8'd0, RunBase + 8'd111);
    send_item(OP_LOAD, 8'd1, RunBase + 8'd111);
    send_item(OP_DATA, 8'($urandom), 8'($urandom));
    send_item(OP_DATA, 8'($urandom), 8'($urandom));
    send_item(OP_LOAD, 8'd0, 8'h01);
    send_item(OP_LOAD, 8'd1, LeafMark + 8'd5);
    resize(512, 1024, 1'b0);
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    // narrower than the current column: row ends on the next pixel
    resize(100, 1024, 1'b0);
    send_item(OP_DATA, 8'($urandom), 8'hFF);
    send_item(OP_DATA, 8'($urandom), 8'hFF);
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned counted;
    hrx_op_e     op;
    logic [7:0]  addr;
    logic [7:0]  data;
    pick = $urandom_range(99);
    if (pick < 10)      w = 0;
    else if (pick < 20) w = $urandom_range(512, 480);
    else if (pick < 28) w = $urandom_range(1023, 513);
    else                w = $urandom_range(40, 1);
    pick = $urandom_range(99);
    if (pick < 10)      h = 0;
    else if (pick < 15) h = $urandom_range(2047, 1025);
    else if (pick < 30) h = $urandom_range(40, 7);
    else                h = $urandom_range(6, 1);
    resize(w, h, 1'b0);
    // half the time the old image carries on under the new size
    if ($urandom_range(1) == 1) send_item(OP_START, 8'($urandom), 8'($urandom));
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(99);
      addr = 8'($urandom);
      data = 8'($urandom);
      if (img_done && pick < 85) begin
        op = OP_START;
      end else if (pick < 8) begin
        op   = OP_LOAD;
        data = rand_entry();
      end else if (pick < 10) begin
        op = OP_START;
      end else if (pick < 11) begin
        op = OP_NONE;
      end else begin
        op = OP_DATA;
      end
      if (op != OP_NONE && !(op == OP_DATA && img_done)) counted++;
      send_item(op, addr, data);
    end
  endtask

  task automatic test_backpressure();
    resize(64, 64, 1'b0);
    send_item(OP_LOAD, 8'd0, RunBase + 8'd15);
    send_item(OP_LOAD, 8'd1, LeafMark + 8'd3);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    stall_req = 1'b1;
    repeat (30) send_item(OP_DATA, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_pause();
    send_item(OP_START, 8'($urandom), 8'($urandom));
    repeat (10) send_item(OP_DATA, 8'($urandom), 8'($urandom));
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
    repeat (10) send_item(OP_DATA, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    cfg_width  = 10'd480;
    cfg_height = 11'd300;
    clear_image();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 31;
    recv_stall_pct = 68;
    test_tree_load();
    test_directed();
    test_size_extremes();
    test_random(40);
    test_random(40);
    test_backpressure();

    send_gap_pct   = 68;
    recv_stall_pct = 31;
    test_random(40);
    test_random(40);
    test_pause();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random(40);
    test_random(40);

    wait_quiet();
    $display("Run covered %0d input beats and %0d pixel words, %0d of them ending an image,",
             beats_sent, words_seen, images_seen);
    $display("under sender gaps, receiver stalls, a long output hold-off and size extremes.");
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### huffman_rle_xor_row_decoder_top.f
rtl/hrx_pkg.sv
rtl/hrx_ram.sv
rtl/hrx_out_buf.sv
rtl/huffman_rle_xor_row_decoder_top.sv
verif/huffman_rle_xor_row_decoder_top_tb.sv
